FILE: design/unsigned_varint_decoder_top_defines.svh
// Assertion macros used by the unsigned varint decoder checker.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef UNSIGNED_VARINT_DECODER_TOP_DEFINES_SVH
`define UNSIGNED_VARINT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset
`define UVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvd assertion failed");

// Next-cycle implication, off during reset
`define UVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvd assertion failed");

`endif

FILE: design/uvd_pkg.sv
// Shared types and constants for the unsigned varint decoder.
// No dependencies; imported by every module of the block.
package uvd_pkg;

  localparam int DATA_W   = 8;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int GROUP_W  = 7;
  localparam int CONT_IDX = 7;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    UVD_OK       = 2'd0,
    UVD_OVERFLOW = 2'd1,
    UVD_NONCANON = 2'd2
  } uvd_status_t;

  // Registered input byte handed to the decode stage
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } uvd_stage_t;

endpackage

FILE: design/uvd_in_stage.sv
// Input register of the unsigned varint decoder.
// Depends on uvd_pkg for the stage struct and byte width.
module uvd_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [uvd_pkg::DATA_W-1:0] in_tdata,   // [7:0] data_byte
  input  logic                       consume_i,
  output uvd_pkg::uvd_stage_t        stage_o
);
  import uvd_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r;
  logic              take;

  // Accept when empty or when the held byte leaves this cycle
  assign in_tready = !valid_r || consume_i;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (consume_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the byte of each accepted transaction
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_tdata;
    end
  end

  assign stage_o.valid = valid_r;
  assign stage_o.data  = data_r;

endmodule

FILE: design/uvd_decode.sv
// Decode stage: accumulator, shift count and the result register.
// Depends on uvd_pkg for status codes, field widths and the stage struct.
module uvd_decode #(
  parameter int VALUE_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  uvd_pkg::uvd_stage_t          stage_i,
  output logic                         consume_o,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [uvd_pkg::VALUE_W-1:0]  out_tdata,  // [63:0] decoded_value
  output logic [uvd_pkg::STATUS_W-1:0] out_tuser   // [1:0] status
);
  import uvd_pkg::*;

  localparam int SH_W  = $clog2(VALUE_BITS);
  localparam int EXT_W = VALUE_BITS + DATA_W;

  logic [VALUE_BITS-1:0] acc_r, acc_nxt, acc_new;
  logic [SH_W-1:0]       sh_r, sh_nxt;
  logic [EXT_W-1:0]      byte_ext, group_ext;
  logic                  ovf, done, noncanon;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    value_r, value_nxt;
  uvd_status_t           status_r, status_nxt;

  // Move the byte on when the result register is free or draining
  assign consume_o = stage_i.valid && (!out_valid_r || out_tready);

  // Place the byte at the current shift and check the bits past the top
  always_comb begin
    byte_ext  = EXT_W'(stage_i.data) << sh_r;
    group_ext = EXT_W'(stage_i.data[GROUP_W-1:0]) << sh_r;
    ovf       = |byte_ext[EXT_W-1:VALUE_BITS];
    acc_new   = acc_r | group_ext[VALUE_BITS-1:0];
    done      = ovf || !stage_i.data[CONT_IDX];
    noncanon  = (stage_i.data == '0) && (sh_r != '0);
  end

  // Advance or restart the accumulator
  always_comb begin
    acc_nxt = acc_r;
    sh_nxt  = sh_r;
    if (consume_o) begin
      if (done) begin
        acc_nxt = '0;
        sh_nxt  = '0;
      end else begin
        acc_nxt = acc_new;
        sh_nxt  = SH_W'(sh_r + SH_W'(GROUP_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sh_r  <= '0;
    end else begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
    end
  end

  // Load a result on a terminating or overflowing byte; drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    if (consume_o && done) begin
      out_valid_nxt = 1'b1;
      if (ovf) begin
        value_nxt  = '0;
        status_nxt = UVD_OVERFLOW;
      end else if (noncanon) begin
        value_nxt  = '0;
        status_nxt = UVD_NONCANON;
      end else begin
        value_nxt  = VALUE_W'(acc_new);
        status_nxt = UVD_OK;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r  <= value_nxt;
    status_r <= status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = value_r;
  assign out_tuser  = status_r;

endmodule

FILE: design/unsigned_varint_decoder_top.sv
// Unsigned varint decoder: takes one byte per transaction and returns one
// result per terminated varint (7 bits a byte, low group first), with status
// ok, value overflow, or non-canonical zero terminator. A new byte is taken
// every cycle while the result register is free or draining. The input register
// captures a byte when accepted; the result register then loads from it.
// The accumulator update through a single shift-and-OR sets that
// one-byte-per-cycle rate. VALUE_BITS (8..64) sets the value width;
// results are zero-extended to 64 bits.
// Depends on uvd_pkg, uvd_in_stage and uvd_decode.
module unsigned_varint_decoder_top #(
  parameter int VALUE_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [uvd_pkg::DATA_W-1:0]   in_tdata,   // [7:0] data_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [uvd_pkg::VALUE_W-1:0]  out_tdata,  // [63:0] decoded_value
  output logic [uvd_pkg::STATUS_W-1:0] out_tuser   // [1:0] status
);
  import uvd_pkg::*;

  uvd_stage_t stage;
  logic       consume;

  uvd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .consume_i (consume),
    .stage_o   (stage)
  );

  uvd_decode #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_i    (stage),
    .consume_o  (consume),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: design/uvd_checker.sv
// Port-level checks for the unsigned varint decoder, bound to the top level.
// Depends on uvd_pkg and the assertion macros in the defines header.
`include "unsigned_varint_decoder_top_defines.svh"

module uvd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [uvd_pkg::DATA_W-1:0]   in_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [uvd_pkg::VALUE_W-1:0]  out_tdata,
  input logic [uvd_pkg::STATUS_W-1:0] out_tuser
);
  import uvd_pkg::*;

  logic [STATUS_W-1:0] st_ok, st_ovf, st_nc;
  logic                in_stall;

  assign st_ok    = UVD_OK;
  assign st_ovf   = UVD_OVERFLOW;
  assign st_nc    = UVD_NONCANON;
  assign in_stall = in_tvalid && !in_tready;

  // Stalled result holds
  `UVD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  // Only defined status codes leave the block
  `UVD_ASSERT_NOW(a_status_code, out_tvalid, out_tuser == st_ok || out_tuser == st_ovf || out_tuser == st_nc)
  // Error results carry a zero value
  `UVD_ASSERT_NOW(a_err_zero, out_tvalid && out_tuser != st_ok, out_tdata == '0)
  // An empty result register never blocks the input
  `UVD_ASSERT_NOW(a_in_ready, !out_tvalid, in_tready)
  // Stalled input transaction holds
  `UVD_ASSERT_NEXT(a_in_hold, in_stall, in_tvalid && $stable(in_tdata))

endmodule

bind unsigned_varint_decoder_top uvd_checker u_uvd_checker (.*);
